FILE: design/sfe_pkg.sv
// shared constants and types of the stereo feedback echo
package sfe_pkg;

   localparam int MEM_DEPTH      = 65536;
   localparam int ADDR_BITS      = $clog2(MEM_DEPTH);
   localparam int SAMPLE_BITS    = 16;
   localparam int GAIN_BITS      = 16;
   localparam int FRAC_BITS      = GAIN_BITS - 1;
   localparam int DELAY_BITS     = ADDR_BITS + 1;

   localparam logic [DELAY_BITS-1:0] DELAY_RESET = DELAY_BITS'(4800);
   localparam logic [GAIN_BITS-1:0]  GAIN_RESET  = GAIN_BITS'(16384);

   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int OUT_DEPTH      = 2;
   localparam int OUT_PTR_BITS   = $clog2(OUT_DEPTH);

   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_BITS  = 32;

   typedef enum logic {
      REG_DELAY_LENGTH  = 1'b0,
      REG_FEEDBACK_GAIN = 1'b1
   } reg_index_type;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [GAIN_BITS-1:0]   gain_type;

   typedef struct packed {
      sample_type left;
      sample_type right;
   } pair_type;

   typedef struct packed {
      pair_type              dry;
      logic [ADDR_BITS-1:0]  rd_addr;
      logic [ADDR_BITS-1:0]  wr_addr;
      logic                  written;
   } desc_type;

endpackage

FILE: design/stereo_feedback_echo.sv
// top level of the stereo feedback comb echo
// Stereo feedback comb echo. Each item pushed on req_ is one dry left/right
// sample pair; for each one the block pops out one result pair on rsp_: the
// pair stored delay_length items ago, scaled by the feedback gain (signed
// Q1.15), plus the dry sample, truncated toward zero and saturated to 16 bits.
// The result is also written back into a 65536-pair delay memory, so echoes
// decay over time. A delay of zero acts as one, a delay above 65536 acts as
// 65536. The memory starts as silence without any clearing pass: a fill
// count tells which entries were ever written, so the block takes items
// right after reset. One item is accepted per cycle, sustained while rsp_pop
// stays high; on its way to rsp_ the descriptor queue takes an item at the
// edge that accepts it, then the delay memory's single registered read
// follows, and then the multiply-add-saturate result lands in the result
// queue. An echo of one item back is served by a bypass around the memory.
// Registers: delay_length at csr byte address 0, the feedback gain at 4;
// write them only while no item is in flight.
module stereo_feedback_echo (
   input  logic                               clock,
   input  logic                               reset,
   // input channel
   input  logic                               req_push,
   output logic                               req_full,
   input  sfe_pkg::sample_type                req_left_in,
   input  sfe_pkg::sample_type                req_right_in,
   // result channel
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output sfe_pkg::sample_type                rsp_left_out,
   output sfe_pkg::sample_type                rsp_right_out,
   // register port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [sfe_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [sfe_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [sfe_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready
);

   logic [sfe_pkg::DELAY_BITS-1:0] delay_ff;
   logic [sfe_pkg::DELAY_BITS-1:0] delay_in;
   sfe_pkg::gain_type              gain_ff;
   sfe_pkg::gain_type              gain_in;
   sfe_pkg::reg_index_type         csr_index;
   logic                           csr_write;

   logic                           q_push;
   logic                           q_full;
   sfe_pkg::desc_type              q_push_desc;
   logic                           q_pop;
   logic                           q_empty;
   sfe_pkg::desc_type              q_pop_desc;

   // register port: no wait states, registers sit at 4 byte steps
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = sfe_pkg::reg_index_type'(csr_paddr[sfe_pkg::CSR_ADDR_BITS-1]);

   always_comb begin
      case (csr_index)
         sfe_pkg::REG_DELAY_LENGTH: begin
            csr_prdata = sfe_pkg::CSR_DATA_BITS'(delay_ff);
         end
         sfe_pkg::REG_FEEDBACK_GAIN: begin
            csr_prdata = sfe_pkg::CSR_DATA_BITS'(gain_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_comb begin
      delay_in = delay_ff;
      gain_in  = gain_ff;
      if (csr_write) begin
         case (csr_index)
            sfe_pkg::REG_DELAY_LENGTH: begin
               delay_in = csr_pwdata[sfe_pkg::DELAY_BITS-1:0];
            end
            sfe_pkg::REG_FEEDBACK_GAIN: begin
               gain_in = csr_pwdata[sfe_pkg::GAIN_BITS-1:0];
            end
            default: begin
               delay_in = delay_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= sfe_pkg::DELAY_RESET;
         gain_ff  <= sfe_pkg::GAIN_RESET;
      end else begin
         delay_ff <= delay_in;
         gain_ff  <= gain_in;
      end
   end

   // front: accepts pairs, computes read/write addresses and fill status
   sfe_front u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (req_push),
      .full         (req_full),
      .delay_length (delay_ff),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_desc       (q_push_desc),
      .left_in      (req_left_in),
      .right_in     (req_right_in)
   );

   // decouples the front from stalls in the back
   sfe_desc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (q_push_desc),
      .full      (q_full),
      .pop       (q_pop),
      .pop_desc  (q_pop_desc),
      .empty     (q_empty)
   );

   // back: memory read, mix, write back, result queue
   sfe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_desc    (q_pop_desc),
      .q_pop     (q_pop),
      .gain      (gain_ff),
      .out_empty (rsp_empty),
      .out_pop   (rsp_pop),
      .left_out  (rsp_left_out),
      .right_out (rsp_right_out)
   );

`ifndef SYNTH
   // nothing waits and nothing is blocked right after reset
   assert property (@(posedge clock) reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

   // every accepted item lands in the descriptor queue with its samples
   assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full) |->
         (q_push && q_push_desc.dry.left == req_left_in
                 && q_push_desc.dry.right == req_right_in))
      else $error("accepted item not queued");

   // the back never takes work from an empty descriptor queue
   assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_empty)
      else $error("pop from empty descriptor queue");

   // a pushed item makes the descriptor queue non-empty on the next cycle
   assert property (@(posedge clock) disable iff (reset) q_push |=> !q_empty)
      else $error("descriptor queue lost an item");
`endif

endmodule

FILE: design/sfe_front.sv
// front end: accepts sample pairs and works out the delay line addresses
module sfe_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   output logic                            full,
   input  logic [sfe_pkg::DELAY_BITS-1:0]  delay_length,
   input  logic                            q_full,
   output logic                            q_push,
   output sfe_pkg::desc_type               q_desc,
   input  sfe_pkg::sample_type             left_in,
   input  sfe_pkg::sample_type             right_in
);

   logic [sfe_pkg::ADDR_BITS-1:0]  wr_pos_ff;
   logic [sfe_pkg::ADDR_BITS-1:0]  wr_pos_in;
   logic                           wrapped_ff;
   logic                           wrapped_in;
   logic [sfe_pkg::DELAY_BITS-1:0] delay_eff;
   logic [sfe_pkg::ADDR_BITS-1:0]  rd_addr;
   logic                           accept;

   // zero acts as one, anything past the depth acts as the depth
   always_comb begin
      if (delay_length == '0) begin
         delay_eff = sfe_pkg::DELAY_BITS'(1);
      end else if (delay_length > sfe_pkg::DELAY_BITS'(sfe_pkg::MEM_DEPTH)) begin
         delay_eff = sfe_pkg::DELAY_BITS'(sfe_pkg::MEM_DEPTH);
      end else begin
         delay_eff = delay_length;
      end
   end

   assign rd_addr = wr_pos_ff - delay_eff[sfe_pkg::ADDR_BITS-1:0];
   assign accept  = push && !q_full;
   assign full    = q_full;
   assign q_push  = accept;

   always_comb begin
      q_desc.dry.left  = left_in;
      q_desc.dry.right = right_in;
      q_desc.rd_addr   = rd_addr;
      q_desc.wr_addr   = wr_pos_ff;
      // fill count: below the write position or after the first wrap
      q_desc.written   = wrapped_ff || (rd_addr < wr_pos_ff);
   end

   always_comb begin
      wr_pos_in  = wr_pos_ff;
      wrapped_in = wrapped_ff;
      if (accept) begin
         wr_pos_in = wr_pos_ff + 1'b1;
         if (wr_pos_ff == sfe_pkg::ADDR_BITS'(sfe_pkg::MEM_DEPTH - 1)) begin
            wrapped_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pos_ff  <= '0;
         wrapped_ff <= 1'b0;
      end else begin
         wr_pos_ff  <= wr_pos_in;
         wrapped_ff <= wrapped_in;
      end
   end

endmodule

FILE: design/sfe_desc_queue.sv
// short queue of work descriptors between front and back
module sfe_desc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sfe_pkg::desc_type push_desc,
   output logic              full,
   input  logic              pop,
   output sfe_pkg::desc_type pop_desc,
   output logic              empty
);

   sfe_pkg::desc_type                 entry_ff [sfe_pkg::QUEUE_DEPTH];
   logic [sfe_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff;
   logic [sfe_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_ff;
   logic [sfe_pkg::QUEUE_PTR_BITS:0]   count_ff;
   logic [sfe_pkg::QUEUE_PTR_BITS:0]   count_in;

   assign full     = count_ff == (sfe_pkg::QUEUE_PTR_BITS + 1)'(sfe_pkg::QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign pop_desc = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

FILE: design/sfe_back.sv
// back end: delay memory, feedback mix with saturation, result queue
module sfe_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  sfe_pkg::desc_type   q_desc,
   output logic                q_pop,
   input  sfe_pkg::gain_type   gain,
   output logic                out_empty,
   input  logic                out_pop,
   output sfe_pkg::sample_type left_out,
   output sfe_pkg::sample_type right_out
);

   localparam int ACC_BITS = sfe_pkg::SAMPLE_BITS + sfe_pkg::GAIN_BITS + 1;
   localparam int Q_BITS   = ACC_BITS - sfe_pkg::FRAC_BITS;
   localparam sfe_pkg::sample_type SAMPLE_MAX = {1'b0, {(sfe_pkg::SAMPLE_BITS-1){1'b1}}};
   localparam sfe_pkg::sample_type SAMPLE_MIN = {1'b1, {(sfe_pkg::SAMPLE_BITS-1){1'b0}}};

   // wet * gain + dry, truncated toward zero, saturated
   function automatic sfe_pkg::sample_type mix(
      sfe_pkg::sample_type wet, sfe_pkg::sample_type dry, sfe_pkg::gain_type g);
      logic signed [sfe_pkg::SAMPLE_BITS+sfe_pkg::GAIN_BITS-1:0] prod;
      logic signed [ACC_BITS-1:0]                                acc;
      logic [Q_BITS-1:0]                                         q;
      prod = wet * g;
      acc  = ACC_BITS'(prod) + (ACC_BITS'(dry) <<< sfe_pkg::FRAC_BITS);
      q    = acc[ACC_BITS-1:sfe_pkg::FRAC_BITS];
      if (acc[ACC_BITS-1] && (acc[sfe_pkg::FRAC_BITS-1:0] != '0)) begin
         q = q + 1'b1;
      end
      if (q[Q_BITS-1:sfe_pkg::SAMPLE_BITS-1] !=
          {(Q_BITS-sfe_pkg::SAMPLE_BITS+1){q[Q_BITS-1]}}) begin
         mix = q[Q_BITS-1] ? SAMPLE_MIN : SAMPLE_MAX;
      end else begin
         mix = q[sfe_pkg::SAMPLE_BITS-1:0];
      end
   endfunction

   sfe_pkg::pair_type              delay_mem_ff [sfe_pkg::MEM_DEPTH];
   sfe_pkg::pair_type              rd_data_ff;
   logic                           byp_hit_ff;
   sfe_pkg::pair_type              byp_data_ff;

   logic                           s2_valid_ff;
   logic                           s2_valid_in;
   sfe_pkg::pair_type              s2_dry_ff;
   logic [sfe_pkg::ADDR_BITS-1:0]  s2_wr_addr_ff;
   logic                           s2_written_ff;

   sfe_pkg::pair_type              wet;
   sfe_pkg::pair_type              result;
   logic                           load;
   logic                           advance;

   sfe_pkg::pair_type              oq_ff [sfe_pkg::OUT_DEPTH];
   logic [sfe_pkg::OUT_PTR_BITS-1:0] oq_wr_ptr_ff;
   logic [sfe_pkg::OUT_PTR_BITS-1:0] oq_rd_ptr_ff;
   logic [sfe_pkg::OUT_PTR_BITS:0]   oq_count_ff;
   logic [sfe_pkg::OUT_PTR_BITS:0]   oq_count_in;
   logic                             oq_full;
   logic                             oq_pop;

   assign oq_full = oq_count_ff == (sfe_pkg::OUT_PTR_BITS + 1)'(sfe_pkg::OUT_DEPTH);
   assign advance = s2_valid_ff && !oq_full;
   assign load    = !q_empty && (!s2_valid_ff || advance);
   assign q_pop   = load;

   always_comb begin
      if (!s2_written_ff) begin
         wet = '0;
      end else if (byp_hit_ff) begin
         wet = byp_data_ff;
      end else begin
         wet = rd_data_ff;
      end
      result.left  = mix(wet.left,  s2_dry_ff.left,  gain);
      result.right = mix(wet.right, s2_dry_ff.right, gain);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         delay_mem_ff[s2_wr_addr_ff] <= result;
      end
   end

   // read port, write-first bypass for a write at the same edge
   always_ff @(posedge clock) begin
      if (load) begin
         rd_data_ff    <= delay_mem_ff[q_desc.rd_addr];
         byp_hit_ff    <= advance && (s2_wr_addr_ff == q_desc.rd_addr);
         byp_data_ff   <= result;
         s2_dry_ff     <= q_desc.dry;
         s2_wr_addr_ff <= q_desc.wr_addr;
         s2_written_ff <= q_desc.written;
      end
   end

   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (load) begin
         s2_valid_in = 1'b1;
      end else if (advance) begin
         s2_valid_in = 1'b0;
      end
   end

   assign oq_pop    = out_pop && !out_empty;
   assign out_empty = oq_count_ff == '0;
   assign left_out  = oq_ff[oq_rd_ptr_ff].left;
   assign right_out = oq_ff[oq_rd_ptr_ff].right;

   always_comb begin
      oq_count_in = oq_count_ff;
      if (advance && !oq_pop) begin
         oq_count_in = oq_count_ff + 1'b1;
      end else if (oq_pop && !advance) begin
         oq_count_in = oq_count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         oq_ff[oq_wr_ptr_ff] <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         oq_wr_ptr_ff <= '0;
         oq_rd_ptr_ff <= '0;
         oq_count_ff  <= '0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         if (advance) begin
            oq_wr_ptr_ff <= oq_wr_ptr_ff + 1'b1;
         end
         if (oq_pop) begin
            oq_rd_ptr_ff <= oq_rd_ptr_ff + 1'b1;
         end
         oq_count_ff <= oq_count_in;
      end
   end

endmodule
